[sv/crs_pkg.sv]
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants for the clock ratio search
// Widths, register indexes, clock generator addresses and data words, the
// sequencer state type and the control structs between the engine modules.
// ----------------------------------------------------------------------------
package crs_pkg;

	// field widths
	localparam int TGT_W  = 16;    // pixel clock
	localparam int CNT_W  = 8;     // multiplier / divider
	localparam int ERR_W  = 24;    // cross-scaled values and errors
	localparam int PROD_W = 32;    // shared multiplier result
	localparam int LIM_W  = 12;    // VCO limits
	localparam int VCO_W  = 14;    // mult*100 and its quotient
	localparam int ADDR_W = 7;
	localparam int DATA_W = 16;

	// arithmetic constants
	localparam logic [ERR_W-1:0] TARGET_SCALE = ERR_W'(1000);
	localparam logic [VCO_W-1:0] VCO_SCALE    = VCO_W'(100);

	// configuration registers
	localparam logic REG_VCO_MIN = 1'b0;
	localparam logic REG_VCO_MAX = 1'b1;
	localparam logic [LIM_W-1:0] VCO_MIN_RST = LIM_W'(600);
	localparam logic [LIM_W-1:0] VCO_MAX_RST = LIM_W'(1200);

	// clock generator port
	localparam logic [ADDR_W-1:0] ADDR_MULT  = 7'h14;
	localparam logic [ADDR_W-1:0] ADDR_DIV   = 7'h16;
	localparam logic [ADDR_W-1:0] ADDR_ODIV0 = 7'h08;
	localparam logic [ADDR_W-1:0] ADDR_ODIV1 = 7'h0a;
	localparam logic [DATA_W-1:0] DATA_BASE  = 16'h1000;
	localparam logic [DATA_W-1:0] DATA_ODIV0 = DATA_BASE | (16'd5 << 6) | 16'd5;
	localparam logic [DATA_W-1:0] DATA_ODIV1 = DATA_BASE | (16'd1 << 6) | 16'd1;

	// top level sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_VCO,
		ST_EMIT
	} state_t;

	// write beat order
	typedef enum logic [1:0] {
		BEAT_MULT,
		BEAT_DIV,
		BEAT_ODIV0,
		BEAT_ODIV1
	} beat_t;

	typedef struct packed {
		logic             start;
		logic [TGT_W-1:0] target;
	} srch_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] best_mult;
		logic [CNT_W-1:0] best_div;
	} srch_rsp_t;

	typedef struct packed {
		logic             start;
		logic [VCO_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [VCO_W-1:0] quotient;
	} div_rsp_t;

	// high count in bits 6 up, low count in bits 0-5
	function automatic logic [DATA_W-1:0] count_word(input logic [CNT_W-1:0] n);
		logic [DATA_W-1:0] half;
		half = DATA_W'(n[CNT_W-1:1]);
		return (half << 6) | (half + DATA_W'(n[0]));
	endfunction

endpackage

[sv/crs_pix_if.sv]
// ----------------------------------------------------------------------------
// crs_pix_if: pixel clock request channel
// Valid/ready channel carrying one requested pixel clock per beat.
// ----------------------------------------------------------------------------
interface crs_pix_if
	import crs_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [TGT_W-1:0] pix_rate;

	modport source (output valid, output pix_rate, input ready);
	modport sink   (input valid, input pix_rate, output ready);
endinterface

[sv/crs_wr_if.sv]
// ----------------------------------------------------------------------------
// crs_wr_if: clock generator write channel
// Valid/ready channel carrying one port write and its search result per beat.
// ----------------------------------------------------------------------------
interface crs_wr_if
	import crs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] port_address;
	logic [DATA_W-1:0] port_data;
	logic [CNT_W-1:0]  best_mult;
	logic [CNT_W-1:0]  best_div;
	logic              vco_out_of_range;
	logic              last_write;

	modport source (output valid, output port_address, output port_data,
		output best_mult, output best_div, output vco_out_of_range,
		output last_write, input ready);
	modport sink   (input valid, input port_address, input port_data,
		input best_mult, input best_div, input vco_out_of_range,
		input last_write, output ready);
endinterface

[sv/crs_search.sv]
// ----------------------------------------------------------------------------
// crs_search: best ratio search engine
// Walks div 1..MAX_DIV and mult 2..MAX_MULT, each candidate in a product and a
// compare phase on one shared multiplier: bd*|1000m - dT| vs d*|1000bm - bdT|.
// ----------------------------------------------------------------------------
module crs_search
	import crs_pkg::*;
#(
	parameter int MAX_MULT = 128,
	parameter int MAX_DIV  = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  srch_req_t req,
	output srch_rsp_t rsp
);

	logic              busy_q;
	logic              phase_q;
	logic              done_q;
	logic [CNT_W-1:0]  m_q;
	logic [CNT_W-1:0]  d_q;
	logic [CNT_W-1:0]  bm_q;
	logic [CNT_W-1:0]  bd_q;
	logic [TGT_W-1:0]  t_q;
	logic [ERR_W-1:0]  cm_q;    // 1000*m
	logic [ERR_W-1:0]  dt_q;    // d*T
	logic [ERR_W-1:0]  eb_q;    // |1000*bm - bd*T|
	logic [PROD_W-1:0] prod_q;  // bd*ec from the first phase

	logic [ERR_W-1:0]  ec;
	logic [ERR_W-1:0]  e_init;
	logic [CNT_W-1:0]  mul_a;
	logic [ERR_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic              better;
	logic              last_m;
	logic              last_d;

	// candidate error and the error of the first candidate (2,1)
	assign ec     = (cm_q >= dt_q) ? cm_q - dt_q : dt_q - cm_q;
	assign e_init = (ERR_W'(2) * TARGET_SCALE >= ERR_W'(req.target))
		? ERR_W'(2) * TARGET_SCALE - ERR_W'(req.target)
		: ERR_W'(req.target) - ERR_W'(2) * TARGET_SCALE;

	// shared multiplier: bd*ec in phase 0, d*eb in phase 1
	assign mul_a  = phase_q ? d_q  : bd_q;
	assign mul_b  = phase_q ? eb_q : ec;
	assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign better = prod_q < mul_p;

	assign last_m = (m_q == CNT_W'(MAX_MULT));
	assign last_d = (d_q == CNT_W'(MAX_DIV));

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q && last_m && last_d) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// loop counters, running products and best pair
	always_ff @(posedge clk) begin
		if (req.start) begin
			t_q  <= req.target;
			m_q  <= CNT_W'(2);
			d_q  <= CNT_W'(1);
			cm_q <= ERR_W'(2) * TARGET_SCALE;
			dt_q <= ERR_W'(req.target);
			bm_q <= CNT_W'(2);
			bd_q <= CNT_W'(1);
			eb_q <= e_init;
		end else if (busy_q) begin
			if (!phase_q) begin
				prod_q <= mul_p;
			end else begin
				if (better) begin
					bm_q <= m_q;
					bd_q <= d_q;
					eb_q <= ec;
				end
				if (last_m) begin
					m_q  <= CNT_W'(2);
					cm_q <= ERR_W'(2) * TARGET_SCALE;
					if (!last_d) begin
						d_q  <= d_q + CNT_W'(1);
						dt_q <= dt_q + ERR_W'(t_q);
					end
				end else begin
					m_q  <= m_q + CNT_W'(1);
					cm_q <= cm_q + TARGET_SCALE;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.best_mult = bm_q;
	assign rsp.best_div  = bd_q;

	// a start never lands on a running search
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("search restarted while busy");

	// done follows the last candidate of a running search
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("search done without a running search");

	// the best pair stays inside the searched ranges
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> bm_q >= CNT_W'(2) && bd_q >= CNT_W'(1)
			&& bm_q <= CNT_W'(MAX_MULT) && bd_q <= CNT_W'(MAX_DIV))
		else $error("best pair out of range");

endmodule

[sv/crs_vco_div.sv]
// ----------------------------------------------------------------------------
// crs_vco_div: serial VCO divider
// Restoring divider, one quotient bit per cycle, for mult*100/div.
// ----------------------------------------------------------------------------
module crs_vco_div
	import crs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(VCO_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [VCO_W-1:0]  num_q;   // dividend shifting out, quotient shifting in
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  dvs_q;

	logic [CNT_W:0]    trial;
	logic              fits;

	assign trial = {rem_q[CNT_W-1:0], num_q[VCO_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VCO_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-subtract datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			num_q <= {num_q[VCO_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

	// remainder stays below the divisor between steps
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(req.start) |-> rem_q < {1'b0, dvs_q})
		else $error("divider remainder not reduced");

	// done closes exactly one run
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a run");

	// no start during a run
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider restarted while busy");

endmodule

[sv/clock_ratio_search_and_pll_words.sv]
// ----------------------------------------------------------------------------
// clock_ratio_search_and_pll_words: PLL ratio search and write sequencer
// Flow: an accepted pixel clock starts the ratio search, whose done starts the
//   VCO divider; its done opens the clock generator write beats. A new
//   pixel clock is taken only once the last write beat is accepted, so output
//   stalls hold off the input.
// Reset: VCO limits return to 600 and 1200, the sequencer goes idle.
// ----------------------------------------------------------------------------
module clock_ratio_search_and_pll_words
	import crs_pkg::*;
#(
	parameter int MAX_MULT = 128,
	parameter int MAX_DIV  = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	crs_pix_if.sink      pix,
	crs_wr_if.source     wr,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	state_t            state_q;
	state_t            state_d;
	beat_t             beat_q;
	logic              warn_q;
	logic [LIM_W-1:0]  vco_min_q;
	logic [LIM_W-1:0]  vco_max_q;

	srch_req_t         srch_req;
	srch_rsp_t         srch_rsp;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic              pix_beat;
	logic              wr_beat;
	logic              cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vco_min_q <= VCO_MIN_RST;
			vco_max_q <= VCO_MAX_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_VCO_MIN: vco_min_q <= pwdata[LIM_W-1:0];
				REG_VCO_MAX: vco_max_q <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_VCO_MIN: prdata = 32'(vco_min_q);
			REG_VCO_MAX: prdata = 32'(vco_max_q);
			default:     prdata = '0;
		endcase
	end

	// engines
	assign pix_beat = pix.valid & pix.ready;
	assign wr_beat  = wr.valid & wr.ready;

	assign srch_req.start  = pix_beat;
	assign srch_req.target = pix.pix_rate;

	assign div_req.start    = srch_rsp.done;
	assign div_req.dividend = VCO_W'(srch_rsp.best_mult) * VCO_SCALE;
	assign div_req.divisor  = srch_rsp.best_div;

	crs_search #(
		.MAX_MULT (MAX_MULT),
		.MAX_DIV  (MAX_DIV)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (srch_req),
		.rsp    (srch_rsp)
	);

	crs_vco_div u_vco_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (pix_beat) state_d = ST_SEARCH;
			ST_SEARCH: if (srch_rsp.done) state_d = ST_VCO;
			ST_VCO:    if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT:   if (wr_beat && beat_q == BEAT_ODIV1) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			beat_q  <= BEAT_MULT;
		end else begin
			state_q <= state_d;
			if (div_rsp.done) begin
				beat_q <= BEAT_MULT;
			end else if (wr_beat) begin
				beat_q <= beat_t'(beat_q + 2'd1);
			end
		end
	end

	// VCO limit check on the finished quotient
	always_ff @(posedge clk) begin
		if (div_rsp.done) begin
			warn_q <= (div_rsp.quotient > VCO_W'(vco_max_q))
				|| (div_rsp.quotient < VCO_W'(vco_min_q));
		end
	end

	// handshake outputs and write payload
	always_comb begin
		pix.ready           = (state_q == ST_IDLE);
		wr.valid            = (state_q == ST_EMIT);
		wr.best_mult        = srch_rsp.best_mult;
		wr.best_div         = srch_rsp.best_div;
		wr.vco_out_of_range = warn_q;
		wr.last_write       = (beat_q == BEAT_ODIV1);
		case (beat_q)
			BEAT_MULT: begin
				wr.port_address = ADDR_MULT;
				wr.port_data    = DATA_BASE | count_word(srch_rsp.best_mult);
			end
			BEAT_DIV: begin
				wr.port_address = ADDR_DIV;
				wr.port_data    = (srch_rsp.best_div == CNT_W'(1))
					? DATA_BASE : count_word(srch_rsp.best_div);
			end
			BEAT_ODIV0: begin
				wr.port_address = ADDR_ODIV0;
				wr.port_data    = DATA_ODIV0;
			end
			BEAT_ODIV1: begin
				wr.port_address = ADDR_ODIV1;
				wr.port_data    = DATA_ODIV1;
			end
			default: begin
				wr.port_address = ADDR_MULT;
				wr.port_data    = DATA_BASE;
			end
		endcase
	end

	// search completion only while searching
	a_srch_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		srch_rsp.done |-> state_q == ST_SEARCH)
		else $error("search done outside the search state");

	// divider completion only while checking the VCO
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_VCO)
		else $error("divider done outside the VCO state");

	// the last write beat returns the block to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_beat && wr.last_write |=> pix.ready)
		else $error("not idle after the last write beat");

	// every write sequence starts with the multiplier word
	a_first_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wr.valid) |-> wr.port_address == ADDR_MULT)
		else $error("write sequence does not start with the multiplier word");

endmodule

[tb/clock_ratio_search_and_pll_words_tb.sv]
// ----------------------------------------------------------------------------
// clock_ratio_search_and_pll_words_tb: self-checking bench for the ratio search
// Sends requested pixel clocks over the valid/ready input and predicts the
// best mult/div pair with an exhaustive search in the bench. It then checks
// each clock generator write beat field by field. The VCO limits
// are reprogrammed over APB between phases, including crossed limits. The
// output side stalls at random and once holds off long enough to back up the
// input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_ratio_search_and_pll_words_tb;
	import crs_pkg::*;

	localparam int MULT_LIMIT = 128;
	localparam int DIV_LIMIT  = 128;

	// APB byte addresses of the two limit registers
	localparam logic [2:0] PADDR_VCO_MIN = 3'(4 * int'(REG_VCO_MIN));
	localparam logic [2:0] PADDR_VCO_MAX = 3'(4 * int'(REG_VCO_MAX));

	// the run limit leaves room for several slow runs
	localparam int RUN_LIMIT    = 12_000_000;
	localparam int HOLD_AFTER   = 26;
	localparam int HOLD_LEN     = 100_000;
	localparam int SETTLE_WAIT  = 33_000;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  mult;
		logic [CNT_W-1:0]  div;
		logic              warn;
		logic              last;
	} pll_write_t;

	// predicts the write beats of each request and checks them in order
	class pll_write_scoreboard;
		pll_write_t pending_writes[$];
		logic [LIM_W-1:0] vco_min;
		logic [LIM_W-1:0] vco_max;
		int errors;
		int requests_accepted;

		function new();
			vco_min = VCO_MIN_RST;
			vco_max = VCO_MAX_RST;
			errors = 0;
			requests_accepted = 0;
		endfunction

		function void set_limits(input logic [LIM_W-1:0] lo, input logic [LIM_W-1:0] hi);
			vco_min = lo;
			vco_max = hi;
		endfunction

		// high count in bits 6 up, low count in bits 0-5, kept to 16 bits
		function logic [DATA_W-1:0] half_count_word(input longint n);
			longint half;
			half = n >> 1;
			return DATA_W'((half << 6) | (half + (n & 1)));
		endfunction

		// exhaustive search, divider outer; strict improvement keeps earliest on tie
		function void note_request(input logic [TGT_W-1:0] pix_rate);
			longint tgt, bm, bd, cur, cand, vco;
			pll_write_t w;
			tgt = longint'(pix_rate);
			bm = 2;
			bd = 1;
			for (longint d = 1; d <= DIV_LIMIT; d++) begin
				for (longint m = 2; m <= MULT_LIMIT; m++) begin
					cur = d * 1000 * bm - d * bd * tgt;
					cand = bd * 1000 * m - d * bd * tgt;
					if (cur < 0) cur = -cur;
					if (cand < 0) cand = -cand;
					if (cand < cur) begin
						bm = m;
						bd = d;
					end
				end
			end
			vco = (bm * 100) / bd;
			w.mult = CNT_W'(bm);
			w.div = CNT_W'(bd);
			w.warn = (vco > longint'(vco_max)) || (vco < longint'(vco_min));
			w.last = 1'b0;
			w.addr = ADDR_MULT;
			w.data = DATA_BASE | half_count_word(bm);
			pending_writes.push_back(w);
			w.addr = ADDR_DIV;
			w.data = (bd == 1) ? DATA_BASE : half_count_word(bd);
			pending_writes.push_back(w);
			w.addr = ADDR_ODIV0;
			w.data = DATA_ODIV0;
			pending_writes.push_back(w);
			w.addr = ADDR_ODIV1;
			w.data = DATA_ODIV1;
			w.last = 1'b1;
			pending_writes.push_back(w);
			requests_accepted++;
		endfunction

		task report_mismatch(input string field, input logic [31:0] want,
				input logic [31:0] got);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", field, want, got,
					$time);
		endtask

		task check_write(input pll_write_t got);
			pll_write_t want;
			if (pending_writes.size() == 0) begin
				report_mismatch("beat with nothing pending, addr", 32'hx, 32'(got.addr));
				return;
			end
			want = pending_writes.pop_front();
			if (got.addr !== want.addr)
				report_mismatch("port_address", 32'(want.addr), 32'(got.addr));
			if (got.data !== want.data)
				report_mismatch("port_data", 32'(want.data), 32'(got.data));
			if (got.mult !== want.mult)
				report_mismatch("best_mult", 32'(want.mult), 32'(got.mult));
			if (got.div !== want.div)
				report_mismatch("best_div", 32'(want.div), 32'(got.div));
			if (got.warn !== want.warn)
				report_mismatch("vco_out_of_range", 32'(want.warn), 32'(got.warn));
			if (got.last !== want.last)
				report_mismatch("last_write", 32'(want.last), 32'(got.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          cycle_count;

	pll_write_scoreboard sb;

	crs_pix_if pix ();
	crs_wr_if  wr ();

	clock_ratio_search_and_pll_words #(
		.MAX_MULT(MULT_LIMIT),
		.MAX_DIV (DIV_LIMIT)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.wr     (wr),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && wr.valid && wr.ready)
			sb.check_write(pll_write_t'{wr.port_address, wr.port_data, wr.best_mult,
				wr.best_div, wr.vco_out_of_range, wr.last_write});
	end

	// receiver: segments of always-ready, coin-flip and mostly-stalled, plus one
	// long hold-off once enough requests are in
	initial begin
		int seg_left;
		int seg_mode;
		bit hold_done;
		seg_left = 0;
		seg_mode = 0;
		hold_done = 1'b0;
		wr.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sb.requests_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				wr.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(1, 40);
					seg_mode = $urandom_range(0, 2);
				end
				seg_left--;
				case (seg_mode)
					0: wr.ready <= 1'b1;
					1: wr.ready <= 1'($urandom_range(0, 1));
					default: wr.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// APB write: setup then access, done at the edge where pready is high
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// upper data bits are random; only the low 12 land in the register
	task automatic program_limits(input logic [LIM_W-1:0] lo, input logic [LIM_W-1:0] hi);
		logic [31:0] word;
		word = $urandom();
		word[LIM_W-1:0] = lo;
		apb_write(PADDR_VCO_MIN, word);
		word = $urandom();
		word[LIM_W-1:0] = hi;
		apb_write(PADDR_VCO_MAX, word);
		sb.set_limits(lo, hi);
	endtask

	// sender: bursts of back-to-back beats with random gaps between bursts
	task automatic drive_pixels(input logic [TGT_W-1:0] clocks[$]);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 6);
		foreach (clocks[i]) begin
			pix.valid <= 1'b1;
			pix.pix_rate <= clocks[i];
			do @(posedge clk); while (!pix.ready);
			sb.note_request(clocks[i]);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 6);
				gap = $urandom_range(0, 12);
				if (gap > 0) begin
					pix.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		pix.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.pending_writes.size() != 0);
	endtask

	// mix of full range, tiny targets, near-exact ratios and the top of the range
	function automatic logic [TGT_W-1:0] random_pix_rate();
		int m;
		int d;
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(1, 65535);
			1: v = $urandom_range(1, 2000);
			2: begin
				m = $urandom_range(2, MULT_LIMIT);
				d = $urandom_range(1, DIV_LIMIT);
				v = m * 1000 / d + $urandom_range(0, 4) - 2;
				if (v < 1) v = 1;
				if (v > 65535) v = 65535;
			end
			default: v = $urandom_range(40000, 65535);
		endcase
		return TGT_W'(v);
	endfunction

	task automatic run_random_phase(input int count);
		logic [TGT_W-1:0] clocks[$];
		repeat (count) clocks.push_back(random_pix_rate());
		drive_pixels(clocks);
		wait_drained();
	endtask

	// main sequence
	initial begin
		logic [TGT_W-1:0] directed[$];
		sb = new();
		arst_n = 1'b0;
		pix.valid <= 1'b0;
		pix.pix_rate <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits; zero target, extremes, exact ratios and ties, bit patterns
		directed = '{16'd0, 16'd1, 16'd2, 16'd500, 16'd999, 16'd1000, 16'd2000,
			16'd15625, 16'd25175, 16'd40000, 16'd42667, 16'd63500, 16'd64000,
			16'd65535, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'd12345,
			16'd33333, 16'd7813};
		drive_pixels(directed);
		wait_drained();

		// widest window the limits allow, quotients above 4095 still flagged; long output hold-off falls here
		program_limits(12'd0, 12'd4095);
		run_random_phase(20);

		// crossed limits flag every pair
		program_limits(12'd4095, 12'd0);
		run_random_phase(15);

		// random window
		program_limits(LIM_W'($urandom_range(0, 2000)), LIM_W'($urandom_range(1000, 4095)));
		run_random_phase(20);

		// single point at the top
		program_limits(12'd4095, 12'd4095);
		run_random_phase(10);

		// back to the reset window
		program_limits(VCO_MIN_RST, VCO_MAX_RST);
		run_random_phase(15);

		repeat (SETTLE_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
